FILE: design/lsas_pkg.sv
// Shared types, constants and helper functions for the LED strip animation sequencer.
// Used by every module of the block; depends on nothing else.
package lsas_pkg;

  localparam int MAX_LEDS = 12;

  localparam logic [7:0]  FULL_LEVEL     = 8'd255;
  localparam logic [11:0] IDLE_WAIT      = 12'd2000;
  localparam logic [11:0] IDLE_REST      = 12'd3000;
  localparam logic [11:0] IDLE_PERIOD    = 12'd100;
  localparam logic [11:0] LISTEN_HALF    = 12'd80;
  localparam logic [11:0] LISTEN_PERIOD  = LISTEN_HALF + LISTEN_HALF;
  localparam logic [11:0] SPEAK_PERIOD   = 12'd20;
  localparam logic [11:0] SPEAK_REST     = 12'd200;
  localparam logic [11:0] ONESHOT_PERIOD = 12'd50;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_MODE = 1'b1;

  localparam logic [2:0] CFG_LED_COUNT    = 3'd0;
  localparam logic [2:0] CFG_LEVEL_STEP   = 3'd1;
  localparam logic [2:0] CFG_IDLE_COLOR   = 3'd2;
  localparam logic [2:0] CFG_LISTEN_COLOR = 3'd3;
  localparam logic [2:0] CFG_SPEAK_COLOR  = 3'd4;
  localparam logic [2:0] CFG_MUTE_COLOR   = 3'd5;
  localparam logic [2:0] CFG_UNMUTE_COLOR = 3'd6;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_LISTEN   = 3'd1,
    MODE_SPEAK    = 3'd2,
    MODE_MUTE     = 3'd3,
    MODE_UNMUTE   = 3'd4,
    MODE_DISABLED = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_UP   = 2'd1,
    PH_DOWN = 2'd2,
    PH_REST = 2'd3
  } phase_t;

  typedef enum logic {
    F_READY = 1'b0,
    F_MOD   = 1'b1
  } fstate_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_MUL  = 2'd1,
    B_DIV  = 2'd2,
    B_EMIT = 2'd3
  } bstate_t;

  typedef struct packed {
    logic [6:0]  led_count;
    logic [7:0]  level_step;
    logic [23:0] idle_color;
    logic [23:0] listen_color;
    logic [23:0] speak_color;
    logic [23:0] mute_color;
    logic [23:0] unmute_color;
  } cfg_t;

  // One frame to be drawn: the animation state right after the step that asked for it.
  typedef struct packed {
    mode_t      mode;
    logic       lit;
    logic [7:0] level;
    logic [5:0] chosen;
    logic [1:0] rot;
  } job_t;

  function automatic logic [6:0] strip_len(input logic [6:0] count);
    logic [6:0] n;
    begin
      if (count < 7'd3) begin
        n = 7'd3;
      end else if (count > 7'(MAX_LEDS)) begin
        n = 7'(MAX_LEDS);
      end else begin
        n = count;
      end
      return n;
    end
  endfunction

  function automatic logic [7:0] step_size(input logic [7:0] step);
    return (step == 8'd0) ? 8'd1 : step;
  endfunction

endpackage

FILE: design/lsas_modu.sv
// Iterative remainder unit: 16-bit dividend modulo a strip length of 3 to 12.
// One dividend bit per cycle, restoring form. Uses lsas_pkg.
module lsas_modu
  import lsas_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [6:0]  divisor,
  output logic        done,
  output logic [5:0]  remainder
);

  logic        busy;
  logic        busy_next;
  logic [3:0]  cnt;
  logic [3:0]  cnt_next;
  logic [15:0] sh;
  logic [15:0] sh_next;
  logic [6:0]  rem;
  logic [6:0]  rem_next;
  logic [6:0]  dsr;
  logic [6:0]  dsr_next;
  logic        done_next;
  logic [6:0]  trial;

  assign trial = {rem[5:0], sh[15]};

  always_comb begin
    busy_next = busy;
    cnt_next  = cnt;
    sh_next   = sh;
    rem_next  = rem;
    dsr_next  = dsr;
    done_next = 1'b0;
    if (start) begin
      busy_next = 1'b1;
      cnt_next  = 4'd0;
      sh_next   = dividend;
      rem_next  = 7'd0;
      dsr_next  = divisor;
    end else if (busy) begin
      rem_next = (trial >= dsr) ? (trial - dsr) : trial;
      sh_next  = {sh[14:0], 1'b0};
      cnt_next = cnt + 4'd1;
      if (cnt == 4'd15) begin
        busy_next = 1'b0;
        done_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 4'd0;
    end else begin
      busy <= busy_next;
      done <= done_next;
      cnt  <= cnt_next;
    end
    sh  <= sh_next;
    rem <= rem_next;
    dsr <= dsr_next;
  end

  assign remainder = rem[5:0];

endmodule

FILE: design/lsas_front.sv
// Front end: accepts ticks and mode commands, keeps the animation state and queues frames.
// Uses lsas_pkg and the remainder unit lsas_modu.
module lsas_front
  import lsas_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [2:0]  new_mode,
  input  logic [15:0] random_word,
  input  logic        q_full,
  output logic        push,
  output job_t        job
);

  fstate_t     fstate;
  fstate_t     fstate_next;
  mode_t       mode;
  mode_t       mode_next;
  phase_t      phase;
  phase_t      phase_next;
  logic [11:0] wait_left;
  logic [11:0] wait_left_next;
  logic [7:0]  level;
  logic [7:0]  level_next;
  logic [5:0]  chosen;
  logic [5:0]  chosen_next;
  logic [1:0]  rot;
  logic [1:0]  rot_next;

  logic        accept;
  logic        pick;
  logic        lit;
  logic        mod_done;
  logic [5:0]  mod_rem;
  logic [6:0]  n;
  logic [7:0]  s;
  logic [8:0]  up_sum;
  logic [11:0] period;

  assign n        = strip_len(cfg.led_count);
  assign s        = step_size(cfg.level_step);
  assign up_sum   = {1'b0, level} + {1'b0, s};
  assign in_ready = (fstate == F_READY) && !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    case (mode)
      MODE_IDLE:  period = IDLE_PERIOD;
      MODE_SPEAK: period = SPEAK_PERIOD;
      default:    period = ONESHOT_PERIOD;
    endcase
  end

  always_comb begin
    fstate_next = fstate;
    case (fstate)
      F_READY: begin
        if (accept && pick) begin
          fstate_next = F_MOD;
        end
      end
      F_MOD: begin
        if (mod_done) begin
          fstate_next = F_READY;
        end
      end
      default: fstate_next = F_READY;
    endcase
  end

  always_comb begin
    mode_next      = mode;
    phase_next     = phase;
    wait_left_next = wait_left;
    level_next     = level;
    chosen_next    = chosen;
    rot_next       = rot;
    push           = 1'b0;
    pick           = 1'b0;
    lit            = 1'b1;
    if (fstate == F_MOD) begin
      if (mod_done) begin
        chosen_next = mod_rem;
        push        = 1'b1;
      end
    end else if (accept && req_type == REQ_TICK) begin
      if (wait_left > 12'd1) begin
        wait_left_next = wait_left - 12'd1;
      end else begin
        wait_left_next = 12'd0;
        case (mode)
          MODE_IDLE, MODE_SPEAK, MODE_MUTE, MODE_UNMUTE: begin
            if (mode == MODE_IDLE && phase == PH_WAIT) begin
              pick           = 1'b1;
              phase_next     = PH_UP;
              level_next     = 8'd0;
              wait_left_next = IDLE_PERIOD;
            end else if (mode == MODE_IDLE && phase == PH_REST) begin
              phase_next     = PH_WAIT;
              wait_left_next = IDLE_WAIT;
              level_next     = 8'd0;
            end else if (mode == MODE_SPEAK && (phase == PH_REST || phase == PH_WAIT)) begin
              phase_next     = PH_UP;
              level_next     = 8'd0;
              wait_left_next = SPEAK_PERIOD;
              push           = 1'b1;
            end else if (phase == PH_UP) begin
              wait_left_next = period;
              push           = 1'b1;
              if (up_sum >= {1'b0, FULL_LEVEL}) begin
                level_next = FULL_LEVEL;
                phase_next = PH_DOWN;
              end else begin
                level_next = up_sum[7:0];
              end
            end else if (level > s) begin
              level_next     = level - s;
              wait_left_next = period;
              push           = 1'b1;
            end else begin
              push       = 1'b1;
              lit        = 1'b0;
              level_next = 8'd0;
              case (mode)
                MODE_IDLE: begin
                  phase_next     = PH_REST;
                  wait_left_next = IDLE_REST;
                end
                MODE_SPEAK: begin
                  phase_next     = PH_REST;
                  wait_left_next = SPEAK_REST;
                end
                default: begin
                  mode_next      = MODE_IDLE;
                  phase_next     = PH_WAIT;
                  wait_left_next = IDLE_WAIT;
                end
              endcase
            end
          end
          MODE_LISTEN: begin
            rot_next       = (rot >= 2'd2) ? 2'd0 : rot + 2'd1;
            wait_left_next = LISTEN_PERIOD;
            push           = 1'b1;
          end
          default: begin
            wait_left_next = 12'd0;
          end
        endcase
      end
    end else if (accept && new_mode <= MODE_DISABLED && new_mode != mode) begin
      case (mode_t'(new_mode))
        MODE_IDLE: begin
          mode_next      = MODE_IDLE;
          phase_next     = PH_WAIT;
          wait_left_next = IDLE_WAIT;
          level_next     = 8'd0;
        end
        MODE_LISTEN: begin
          mode_next      = MODE_LISTEN;
          phase_next     = PH_WAIT;
          level_next     = 8'd0;
          rot_next       = 2'd0;
          wait_left_next = LISTEN_PERIOD;
          push           = 1'b1;
        end
        MODE_SPEAK: begin
          mode_next      = MODE_SPEAK;
          phase_next     = PH_UP;
          level_next     = 8'd0;
          wait_left_next = SPEAK_PERIOD;
          push           = 1'b1;
        end
        MODE_MUTE, MODE_UNMUTE: begin
          mode_next      = mode_t'(new_mode);
          phase_next     = PH_UP;
          level_next     = 8'd0;
          wait_left_next = ONESHOT_PERIOD;
          push           = 1'b1;
        end
        default: begin
          mode_next      = MODE_DISABLED;
          phase_next     = PH_WAIT;
          level_next     = 8'd0;
          wait_left_next = 12'd0;
          push           = 1'b1;
          lit            = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    job.mode   = mode_next;
    job.lit    = lit;
    job.level  = level_next;
    job.chosen = chosen_next;
    job.rot    = rot_next;
  end

  lsas_modu u_modu (
    .clk       (clk),
    .rst       (rst),
    .start     (pick),
    .dividend  (random_word),
    .divisor   (n),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate    <= F_READY;
      mode      <= MODE_IDLE;
      phase     <= PH_WAIT;
      wait_left <= 12'd0;
      level     <= 8'd0;
      chosen    <= 6'd0;
      rot       <= 2'd0;
    end else begin
      fstate    <= fstate_next;
      mode      <= mode_next;
      phase     <= phase_next;
      wait_left <= wait_left_next;
      level     <= level_next;
      chosen    <= chosen_next;
      rot       <= rot_next;
    end
  end

  a_done_in_mod : assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (fstate == F_MOD))
    else $error("remainder finished outside of the LED pick");

  a_push_space : assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("frame pushed into a full queue");

  a_wait_bound : assert property (@(posedge clk) disable iff (rst)
    wait_left <= IDLE_REST)
    else $error("wait counter beyond the longest wait");

  a_pick_ramp : assert property (@(posedge clk) disable iff (rst)
    (fstate == F_MOD) |-> (mode == MODE_IDLE && phase == PH_UP && level == 8'd0))
    else $error("LED pick pending without a fresh idle ramp");

endmodule

FILE: design/lsas_queue.sv
// Two-entry frame queue between the front end and the pixel back end.
// Uses lsas_pkg for the frame type.
module lsas_queue
  import lsas_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

FILE: design/lsas_back.sv
// Back end: takes one queued frame, scales its color once (listen color unscaled), then sends
// one pixel word per cycle while the receiver is ready. Uses lsas_pkg.
module lsas_back
  import lsas_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  job_t        head,
  input  logic        q_empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  pixel_index,
  output logic [23:0] pixel_color,
  output logic        frame_end,
  output logic [2:0]  mode_now
);

  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    begin
      t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
      return t[15:8];
    end
  endfunction

  bstate_t     bstate;
  bstate_t     bstate_next;
  job_t        cur;
  logic [6:0]  n;
  logic [23:0] base_color;
  logic [15:0] prod_r;
  logic [15:0] prod_g;
  logic [15:0] prod_b;
  logic [23:0] scaled;
  logic [5:0]  idx;
  logic [6:0]  grp;
  logic [1:0]  m3;
  logic        en;
  logic        last;
  logic [23:0] color;

  assign en   = !out_valid || out_ready;
  assign last = ({1'b0, idx} + 7'd1 == n);
  assign pop  = (bstate == B_IDLE) && !q_empty;

  always_comb begin
    case (cur.mode)
      MODE_IDLE:   base_color = cfg.idle_color;
      MODE_SPEAK:  base_color = cfg.speak_color;
      MODE_MUTE:   base_color = cfg.mute_color;
      MODE_UNMUTE: base_color = cfg.unmute_color;
      default:     base_color = 24'd0;
    endcase
  end

  always_comb begin
    bstate_next = bstate;
    case (bstate)
      B_IDLE: begin
        if (!q_empty) begin
          bstate_next = B_MUL;
        end
      end
      B_MUL:  bstate_next = B_DIV;
      B_DIV:  bstate_next = B_EMIT;
      B_EMIT: begin
        if (en && last) begin
          bstate_next = B_IDLE;
        end
      end
      default: bstate_next = B_IDLE;
    endcase
  end

  always_comb begin
    color = 24'd0;
    if (cur.lit) begin
      case (cur.mode)
        MODE_IDLE: begin
          if (idx == cur.chosen) begin
            color = scaled;
          end
        end
        MODE_LISTEN: begin
          if (m3 == cur.rot && (grp + 7'd3) <= n) begin
            color = scaled;
          end
        end
        MODE_SPEAK, MODE_MUTE, MODE_UNMUTE: color = scaled;
        default: color = 24'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate    <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      bstate <= bstate_next;
      if (bstate == B_EMIT && en) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (pop) begin
      cur <= head;
      n   <= strip_len(cfg.led_count);
    end
    if (bstate == B_MUL) begin
      prod_r <= {8'd0, base_color[23:16]} * {8'd0, cur.level};
      prod_g <= {8'd0, base_color[15:8]} * {8'd0, cur.level};
      prod_b <= {8'd0, base_color[7:0]} * {8'd0, cur.level};
    end
    if (bstate == B_DIV) begin
      idx <= 6'd0;
      grp <= 7'd0;
      m3  <= 2'd0;
      if (cur.mode == MODE_LISTEN) begin
        scaled <= cfg.listen_color;
      end else begin
        scaled <= {div255(prod_r), div255(prod_g), div255(prod_b)};
      end
    end
    if (bstate == B_EMIT && en) begin
      pixel_index <= idx;
      pixel_color <= color;
      frame_end   <= last;
      mode_now    <= cur.mode;
      idx         <= idx + 6'd1;
      if (m3 == 2'd2) begin
        m3  <= 2'd0;
        grp <= grp + 7'd3;
      end else begin
        m3 <= m3 + 2'd1;
      end
    end
  end

  a_idx_range : assert property (@(posedge clk) disable iff (rst)
    (bstate == B_EMIT) |-> ({1'b0, idx} < n))
    else $error("pixel index ran past the strip length");

  a_group_phase : assert property (@(posedge clk) disable iff (rst)
    (bstate == B_EMIT) |-> (m3 != 2'd3 && grp + {5'd0, m3} == {1'b0, idx}))
    else $error("group counters out of step with the pixel index");

  a_last_closes : assert property (@(posedge clk) disable iff (rst)
    (bstate == B_EMIT && en && last) |=> (out_valid && frame_end && bstate == B_IDLE))
    else $error("last pixel did not close the frame");

endmodule

FILE: design/led_strip_animation_sequencer_unit.sv
// Top level of the LED strip animation sequencer: configuration registers and the
// front end, frame queue and pixel back end. Uses lsas_pkg, lsas_front, lsas_queue, lsas_back.
//
//   channel   direction  handshake                 payload
//   s_axis    in         s_axis_tvalid/tready      tdata: new_mode, random_word; tuser: req_type
//   m_axis    out        m_axis_tvalid/tready      tdata: pixel_index, pixel_color, mode_now;
//                                                  tlast: frame_end
//   cfg       in         cfg_we                    cfg_index, cfg_data
//
// The front end acts on a tick or command as it is taken; a tick picking the idle LED
// holds the input until the remainder unit, running one bit per cycle, is done.
// A popped frame passes the back end's multiply and divide states, then its n pixel words
// leave one a cycle while the receiver is ready. Two frames may wait in the queue; apart
// from the LED pick, the input stalls only when the queue is full. Reset is synchronous;
// it resets control state and configuration, not the datapath registers.
module led_strip_animation_sequencer_unit
  import lsas_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // new_mode[2:0], random_word[18:3], zero fill
  input  logic        s_axis_tuser,   // req_type[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // pixel_index[5:0], pixel_color[29:6], mode_now[32:30]
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  cfg_t        cfg;
  logic        push;
  job_t        push_job;
  logic        pop;
  job_t        head;
  logic        q_empty;
  logic        q_full;
  logic [5:0]  pixel_index;
  logic [23:0] pixel_color;
  logic [2:0]  mode_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.led_count    <= 7'd12;
      cfg.level_step   <= 8'd5;
      cfg.idle_color   <= 24'd0;
      cfg.listen_color <= 24'd0;
      cfg.speak_color  <= 24'd0;
      cfg.mute_color   <= 24'd0;
      cfg.unmute_color <= 24'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LED_COUNT:    cfg.led_count    <= cfg_data[6:0];
        CFG_LEVEL_STEP:   cfg.level_step   <= cfg_data[7:0];
        CFG_IDLE_COLOR:   cfg.idle_color   <= cfg_data;
        CFG_LISTEN_COLOR: cfg.listen_color <= cfg_data;
        CFG_SPEAK_COLOR:  cfg.speak_color  <= cfg_data;
        CFG_MUTE_COLOR:   cfg.mute_color   <= cfg_data;
        CFG_UNMUTE_COLOR: cfg.unmute_color <= cfg_data;
        default: ;
      endcase
    end
  end

  lsas_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .req_type    (s_axis_tuser),
    .new_mode    (s_axis_tdata[2:0]),
    .random_word (s_axis_tdata[18:3]),
    .q_full      (q_full),
    .push        (push),
    .job         (push_job)
  );

  lsas_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  lsas_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head        (head),
    .q_empty     (q_empty),
    .pop         (pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .pixel_index (pixel_index),
    .pixel_color (pixel_color),
    .frame_end   (m_axis_tlast),
    .mode_now    (mode_now)
  );

  assign m_axis_tdata = {7'd0, mode_now, pixel_color, pixel_index};

endmodule

FILE: bench/pixel_stream_checker.sv
`timescale 1ns / 100ps
// Checker for the LED strip animation sequencer: it follows the command, configuration
// and pixel channels, predicts every pixel word and compares it field by field. Uses lsas_pkg.
module pixel_stream_checker
  import lsas_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // new_mode[2:0], random_word[18:3], zero fill
  input  logic        s_axis_tuser,   // req_type[0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // pixel_index[5:0], pixel_color[29:6], mode_now[32:30]
  input  logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output int          fail_count,
  output int          words_pending
);

  typedef struct packed {
    logic [5:0]  index;
    logic [23:0] color;
    logic        last;
    mode_t       mode;
  } pixel_word_t;

  pixel_word_t due_pixels[$];

  logic [6:0]  led_cnt;
  logic [7:0]  lvl_step;
  logic [23:0] idle_rgb;
  logic [23:0] listen_rgb;
  logic [23:0] speak_rgb;
  logic [23:0] mute_rgb;
  logic [23:0] unmute_rgb;

  mode_t       mode_q;
  phase_t      phase_q;
  logic [11:0] wait_left;
  int          level;
  logic [5:0]  chosen;
  logic [1:0]  rot;

  function automatic int strip_n();
    if (led_cnt < 7'd3) begin
      return 3;
    end
    if (int'(led_cnt) > MAX_LEDS) begin
      return MAX_LEDS;
    end
    return int'(led_cnt);
  endfunction

  function automatic int step_n();
    return (lvl_step == 8'd0) ? 1 : int'(lvl_step);
  endfunction

  function automatic logic [23:0] scaled(input logic [23:0] rgb, input int lvl);
    int r;
    int g;
    int b;
    r = int'(rgb[23:16]) * lvl / 255;
    g = int'(rgb[15:8]) * lvl / 255;
    b = int'(rgb[7:0]) * lvl / 255;
    return {8'(r), 8'(g), 8'(b)};
  endfunction

  function automatic logic [23:0] lit_color(input int i, input int n);
    case (mode_q)
      MODE_IDLE:   return (i == int'(chosen)) ? scaled(idle_rgb, level) : 24'd0;
      MODE_LISTEN: return (i < (n / 3) * 3 && (i % 3) == int'(rot)) ? listen_rgb : 24'd0;
      MODE_SPEAK:  return scaled(speak_rgb, level);
      MODE_MUTE:   return scaled(mute_rgb, level);
      MODE_UNMUTE: return scaled(unmute_rgb, level);
      default:     return 24'd0;
    endcase
  endfunction

  task automatic emit_frame(input bit lit);
    int n;
    pixel_word_t w;
    n = strip_n();
    for (int i = 0; i < n; i++) begin
      w.index = 6'(i);
      w.color = lit ? lit_color(i, n) : 24'd0;
      w.last  = (i == n - 1);
      w.mode  = mode_q;
      due_pixels.push_back(w);
    end
  endtask

  task automatic go_idle();
    mode_q    = MODE_IDLE;
    phase_q   = PH_WAIT;
    wait_left = IDLE_WAIT;
    level     = 0;
  endtask

  task automatic begin_ramp(input logic [11:0] period);
    phase_q   = PH_UP;
    level     = 0;
    wait_left = period;
    emit_frame(1'b1);
  endtask

  // One step of a breath; sent goes low once the ramp is down and nothing was drawn.
  task automatic ramp_step(input logic [11:0] period, output bit sent);
    int s;
    s = step_n();
    sent = 1'b1;
    if (phase_q == PH_UP) begin
      level = level + s;
      if (level >= int'(FULL_LEVEL)) begin
        level   = int'(FULL_LEVEL);
        phase_q = PH_DOWN;
      end
      wait_left = period;
      emit_frame(1'b1);
    end else if (level > s) begin
      level     = level - s;
      wait_left = period;
      emit_frame(1'b1);
    end else begin
      sent = 1'b0;
    end
  endtask

  task automatic on_expiry(input logic [15:0] rnd);
    bit sent;
    case (mode_q)
      MODE_IDLE: begin
        if (phase_q == PH_WAIT) begin
          chosen = 6'(int'(rnd) % strip_n());
          begin_ramp(IDLE_PERIOD);
        end else if (phase_q == PH_REST) begin
          go_idle();
        end else begin
          ramp_step(IDLE_PERIOD, sent);
          if (!sent) begin
            level     = 0;
            phase_q   = PH_REST;
            wait_left = IDLE_REST;
            emit_frame(1'b0);
          end
        end
      end
      MODE_LISTEN: begin
        rot       = (rot >= 2'd2) ? 2'd0 : rot + 2'd1;
        wait_left = LISTEN_PERIOD;
        emit_frame(1'b1);
      end
      MODE_SPEAK: begin
        if (phase_q == PH_REST || phase_q == PH_WAIT) begin
          begin_ramp(SPEAK_PERIOD);
        end else begin
          ramp_step(SPEAK_PERIOD, sent);
          if (!sent) begin
            level     = 0;
            phase_q   = PH_REST;
            wait_left = SPEAK_REST;
            emit_frame(1'b0);
          end
        end
      end
      MODE_MUTE, MODE_UNMUTE: begin
        ramp_step(ONESHOT_PERIOD, sent);
        if (!sent) begin
          go_idle();
          emit_frame(1'b0);
        end
      end
      default: begin
        wait_left = 12'd0;
      end
    endcase
  endtask

  task automatic advance_animation(input logic req, input logic [2:0] nm,
                                   input logic [15:0] rnd);
    if (req == REQ_TICK) begin
      if (wait_left > 12'd1) begin
        wait_left = wait_left - 12'd1;
      end else begin
        wait_left = 12'd0;
        on_expiry(rnd);
      end
    end else if (nm <= MODE_DISABLED && nm != mode_q) begin
      case (nm)
        MODE_IDLE: begin
          go_idle();
        end
        MODE_LISTEN: begin
          mode_q    = MODE_LISTEN;
          phase_q   = PH_WAIT;
          level     = 0;
          rot       = 2'd0;
          wait_left = LISTEN_PERIOD;
          emit_frame(1'b1);
        end
        MODE_SPEAK: begin
          mode_q = MODE_SPEAK;
          begin_ramp(SPEAK_PERIOD);
        end
        MODE_MUTE, MODE_UNMUTE: begin
          mode_q = mode_t'(nm);
          begin_ramp(ONESHOT_PERIOD);
        end
        default: begin
          mode_q    = MODE_DISABLED;
          phase_q   = PH_WAIT;
          level     = 0;
          wait_left = 12'd0;
          emit_frame(1'b0);
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    pixel_word_t want;
    if (rst) begin
      led_cnt    = 7'd12;
      lvl_step   = 8'd5;
      idle_rgb   = 24'd0;
      listen_rgb = 24'd0;
      speak_rgb  = 24'd0;
      mute_rgb   = 24'd0;
      unmute_rgb = 24'd0;
      mode_q     = MODE_IDLE;
      phase_q    = PH_WAIT;
      wait_left  = 12'd0;
      level      = 0;
      chosen     = 6'd0;
      rot        = 2'd0;
      fail_count = 0;
      due_pixels.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_pixels.size() == 0) begin
          $error("pixel word with no frame due: pixel_index %0d", m_axis_tdata[5:0]);
          fail_count++;
        end else begin
          want = due_pixels.pop_front();
          if (m_axis_tdata[5:0] !== want.index) begin
            $error("pixel_index: expected %0d, got %0d", want.index, m_axis_tdata[5:0]);
            fail_count++;
          end
          if (m_axis_tdata[29:6] !== want.color) begin
            $error("pixel_color: expected %06h, got %06h", want.color, m_axis_tdata[29:6]);
            fail_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("frame_end: expected %0d, got %0d", want.last, m_axis_tlast);
            fail_count++;
          end
          if (m_axis_tdata[32:30] !== want.mode) begin
            $error("mode_now: expected %0d, got %0d", want.mode, m_axis_tdata[32:30]);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_LED_COUNT:    led_cnt    = cfg_data[6:0];
          CFG_LEVEL_STEP:   lvl_step   = cfg_data[7:0];
          CFG_IDLE_COLOR:   idle_rgb   = cfg_data;
          CFG_LISTEN_COLOR: listen_rgb = cfg_data;
          CFG_SPEAK_COLOR:  speak_rgb  = cfg_data;
          CFG_MUTE_COLOR:   mute_rgb   = cfg_data;
          CFG_UNMUTE_COLOR: unmute_rgb = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        advance_animation(s_axis_tuser, s_axis_tdata[2:0], s_axis_tdata[18:3]);
      end
    end
    words_pending = due_pixels.size();
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// Top of the bench for led_strip_animation_sequencer_unit: clock, reset, configuration
// phases and tick and mode command stimulus. Uses lsas_pkg and pixel_stream_checker.
module testbench
  import lsas_pkg::*;
();

  localparam int LIMIT_CYCLES   = 4000000;
  localparam int SETTLE_CYCLES  = 48;
  localparam int NUM_PHASES     = 6;
  localparam int ACTIONS_PER_PH = 2;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;

  int fail_count;
  int words_pending;
  int cycles = 0;
  int burst_left = 0;
  int rx_style = 0;
  int rx_left = 0;

  led_strip_animation_sequencer_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  pixel_stream_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // The pixel side switches between free flow, light and heavy stalling, and a periodic on-off pattern.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_style <= $urandom_range(0, 3);
      rx_left  <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_style)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
      2:       m_axis_tready <= ($urandom_range(0, 7) == 0);
      default: m_axis_tready <= rx_left[2];
    endcase
  end

  task automatic send_word(input logic req, input logic [2:0] nm, input logic [15:0] rnd);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {5'd0, rnd, nm};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic mode_cmd(input logic [2:0] nm, input logic [15:0] rnd);
    send_word(REQ_MODE, nm, rnd);
  endtask

  // The last tick of a run carries the given random word, the others random ones.
  task automatic tick_run(input int count, input logic [15:0] last_rnd);
    for (int k = 1; k <= count; k++) begin
      send_word(REQ_TICK, 3'($urandom_range(0, 7)),
                (k == count) ? last_rnd : 16'($urandom_range(0, 65535)));
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (words_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [23:0] phase_color(input int p);
    if (p == 1) begin
      return 24'hFFFFFF;
    end
    if (p == 5) begin
      return 24'd0;
    end
    return 24'($urandom_range(0, 24'hFFFFFF));
  endfunction

  task automatic load_phase(input int p);
    logic [6:0] cnt;
    logic [7:0] stp;
    case (p)
      0:       begin cnt = 7'd3;   stp = 8'd0;   end
      1:       begin cnt = 7'd64;  stp = 8'd255; end
      2:       begin cnt = 7'd0;   stp = 8'd128; end
      3:       begin cnt = 7'd127; stp = 8'd1;   end
      4:       begin cnt = 7'($urandom_range(3, 64)); stp = 8'($urandom_range(1, 255)); end
      default: begin cnt = 7'($urandom_range(3, 12)); stp = 8'($urandom_range(2, 40)); end
    endcase
    write_reg(CFG_LED_COUNT, {17'd0, cnt});
    write_reg(CFG_LEVEL_STEP, {16'd0, stp});
    write_reg(CFG_IDLE_COLOR, phase_color(p));
    write_reg(CFG_LISTEN_COLOR, phase_color(p));
    write_reg(CFG_SPEAK_COLOR, phase_color(p));
    write_reg(CFG_MUTE_COLOR, phase_color(p));
    write_reg(CFG_UNMUTE_COLOR, phase_color(p));
    cfg_we <= 1'b0;
  endtask

  initial begin
    int pick;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 24'd0;
    s_axis_tuser  <= REQ_TICK;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_LED_COUNT;
    cfg_data      <= 24'd0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(CFG_LED_COUNT, 24'd12);
    write_reg(CFG_LEVEL_STEP, 24'd255);
    write_reg(CFG_IDLE_COLOR, 24'hFFFFFF);
    write_reg(CFG_LISTEN_COLOR, 24'hA5C3F0);
    write_reg(CFG_SPEAK_COLOR, 24'h80FF01);
    write_reg(CFG_MUTE_COLOR, 24'hFF0080);
    write_reg(CFG_UNMUTE_COLOR, 24'h017FFE);
    cfg_we <= 1'b0;

    // Right after reset the idle wait is already over, so the first tick picks an LED.
    tick_run(1, 16'hFFFF);
    mode_cmd(3'd6, 16'h0000);
    mode_cmd(3'd7, 16'hFFFF);
    mode_cmd(MODE_IDLE, 16'h5A5A);
    mode_cmd(MODE_LISTEN, 16'h0000);
    mode_cmd(MODE_LISTEN, 16'hFFFF);
    mode_cmd(MODE_SPEAK, 16'h1234);
    tick_run(20, 16'h0001);
    tick_run(20, 16'h8000);
    mode_cmd(MODE_MUTE, 16'hFFFF);
    mode_cmd(MODE_UNMUTE, 16'h0000);
    mode_cmd(MODE_DISABLED, 16'h0000);
    tick_run(1, 16'hFFFF);
    mode_cmd(MODE_DISABLED, 16'hFFFF);
    mode_cmd(MODE_IDLE, 16'h0000);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      load_phase(p);
      mode_cmd(3'($urandom_range(1, 5)), 16'($urandom_range(0, 65535)));
      for (int a = 0; a < ACTIONS_PER_PH; a++) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          mode_cmd(3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)));
        end else begin
          tick_run($urandom_range(1, 20), 16'($urandom_range(0, 65535)));
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
